[hdl/dq_pkg.sv]
`default_nettype none

package dq_pkg;

	localparam int unsigned WORD_W = 32;

	typedef enum logic [1:0] {
		MODE_PUSH_FRONT = 2'd0,
		MODE_PUSH_BACK  = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_POP_BACK   = 2'd3
	} dq_mode_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic shift_in_front;  // push at front: every cell takes its left neighbor
		logic shift_out_front; // pop at front: every cell takes its right neighbor
		logic load_back;       // push at back: the cell just past the tail loads the word
	} dq_cell_ctl_t;

endpackage

`default_nettype wire

[hdl/dq_cell.sv]
`default_nettype none

module dq_cell (
	input  wire                                clk,
	input  wire dq_pkg::dq_cell_ctl_t          ctl,
	input  wire                                tail_hit,
	input  wire logic signed [dq_pkg::WORD_W-1:0] left_data,
	input  wire logic signed [dq_pkg::WORD_W-1:0] right_data,
	input  wire logic signed [dq_pkg::WORD_W-1:0] push_data,
	output logic signed [dq_pkg::WORD_W-1:0]      data_q
);
	import dq_pkg::*;

	// payload only: an entry is read only after it was written
	always_ff @(posedge clk) begin
		if (ctl.shift_in_front) begin
			data_q <= left_data;
		end else if (ctl.shift_out_front) begin
			data_q <= right_data;
		end else if (ctl.load_back && tail_hit) begin
			data_q <= push_data;
		end
	end

endmodule

`default_nettype wire

[hdl/double_ended_queue_core.sv]
`default_nettype none

// Bounded double-ended queue of signed 32-bit words, built as a row of DEPTH
// cells. The front element always sits in cell 0 and the elements fill the
// row contiguously, so a push at the front shifts the whole row one cell
// toward the back, a pop at the front shifts it one cell toward the front,
// a push at the back loads the cell just past the tail, and a pop at the back
// reads the tail cell. Every input word gives exactly one result word: ok,
// the popped value (zero for pushes and failed pops) and the element count
// after the operation. A push into a full queue and a pop from an empty queue
// fail with ok low and leave the contents unchanged. Rate: one operation per
// clock unless in_stall holds the input; each result appears in the output
// register on the cycle after its word is accepted. The output register is
// the only holding point, so in_stall is high only while a finished result
// is held there by out_stall. No clearing pass is needed after reset: the
// queue starts empty and cells are read only after they were written. The
// count port is $clog2(DEPTH+1) bits wide.
module double_ended_queue_core #(
	parameter int DEPTH = 16
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          mode,
	input  wire logic signed [dq_pkg::WORD_W-1:0]    data_in,
	output logic                                     out_valid,
	input  wire                                      out_stall,
	output logic                                     ok,
	output logic signed [dq_pkg::WORD_W-1:0]         data_out,
	output logic [$clog2(DEPTH+1)-1:0]               count
);
	import dq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic signed [WORD_W-1:0] cell_data [DEPTH];
	logic [CW-1:0]            cnt_q;
	logic [CW-1:0]            cnt_next;
	logic [CW-1:0]            tail_idx;
	logic                     in_fire;
	logic                     full;
	logic                     empty;
	logic                     is_pop;
	logic                     op_ok;
	logic signed [WORD_W-1:0] pop_value;
	dq_mode_t                 op;
	dq_cell_ctl_t             ctl;

	logic                     out_valid_q;
	logic                     ok_q;
	logic signed [WORD_W-1:0] data_out_q;
	logic [CW-1:0]            count_q;

	// accept whenever the output register is free or being emptied
	assign in_stall = out_valid_q && out_stall;
	assign in_fire  = in_valid && !in_stall;

	assign op       = dq_mode_t'(mode);
	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign tail_idx = cnt_q - CW'(1);

	always_comb begin
		is_pop = op inside {MODE_POP_FRONT, MODE_POP_BACK};
		op_ok  = is_pop ? !empty : !full;
	end

	// drive the row: only a successful, accepted operation moves anything
	always_comb begin
		ctl       = '0;
		pop_value = '0;
		cnt_next  = cnt_q;
		case (op)
			MODE_PUSH_FRONT: begin
				ctl.shift_in_front = in_fire && op_ok;
				cnt_next           = cnt_q + CW'(1);
			end
			MODE_PUSH_BACK: begin
				ctl.load_back = in_fire && op_ok;
				cnt_next      = cnt_q + CW'(1);
			end
			MODE_POP_FRONT: begin
				ctl.shift_out_front = in_fire && op_ok;
				pop_value           = cell_data[0];
				cnt_next            = cnt_q - CW'(1);
			end
			MODE_POP_BACK: begin
				pop_value = cell_data[tail_idx[AW-1:0]];
				cnt_next  = cnt_q - CW'(1);
			end
			default: begin
				pop_value = '0;
			end
		endcase
		if (!op_ok) begin
			pop_value = '0;
			cnt_next  = cnt_q;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic signed [WORD_W-1:0] left_w;
			logic signed [WORD_W-1:0] right_w;
			logic                     hit_w;

			if (gi == 0) begin : g_first
				assign left_w = data_in;
			end else begin : g_mid_l
				assign left_w = cell_data[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_last
				assign right_w = cell_data[gi];
			end else begin : g_mid_r
				assign right_w = cell_data[gi+1];
			end

			assign hit_w = (cnt_q == CW'(gi));

			dq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.tail_hit   (hit_w),
				.left_data  (left_w),
				.right_data (right_w),
				.push_data  (data_in),
				.data_q     (cell_data[gi])
			);
		end
	endgenerate

	// element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_fire) begin
			cnt_q <= cnt_next;
		end
	end

	// output register: load on accept, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ok_q       <= op_ok;
			data_out_q <= pop_value;
			count_q    <= cnt_next;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign data_out  = data_out_q;
	assign count     = count_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("element count beyond depth");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && is_pop && !empty |=> cnt_q == $past(cnt_q) - CW'(1))
		else $error("successful pop did not decrement count");

	a_fail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !op_ok |=> $stable(cnt_q))
		else $error("failed operation changed count");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid && count == cnt_q)
		else $error("result count differs from element count");
`endif

endmodule

`default_nettype wire

[dv/double_ended_queue_core_test.sv]
`timescale 1ns / 100ps

module double_ended_queue_core_test;
	import dq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 435;
	localparam int MAX_GAP     = 40;

	typedef struct packed {
		logic                     ok;
		logic [WORD_W-1:0]        data;
		logic [CNT_W-1:0]         count;
	} deque_result_t;

	// one stimulus word; lit marks rows whose result is typed in by hand
	typedef struct packed {
		dq_mode_t                 op;
		logic [WORD_W-1:0]        word;
		logic                     lit;
		deque_result_t            want;
	} deque_word_t;

	localparam deque_word_t DIRECTED_ROWS [15] = '{
		// empty queue right after reset: both pops fail
		'{MODE_POP_FRONT,  32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 5'd0}},
		'{MODE_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 5'd0}},
		// extremes at both ends; the first push at front wraps the head
		'{MODE_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 5'd1}},
		'{MODE_PUSH_FRONT, 32'h8000_0000, 1'b1, '{1'b1, 32'h0000_0000, 5'd2}},
		'{MODE_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 5'd3}},
		'{MODE_PUSH_FRONT, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 5'd4}},
		'{MODE_POP_FRONT,  32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 5'd3}},
		'{MODE_POP_BACK,   32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 5'd2}},
		'{MODE_PUSH_FRONT, 32'h1234_5678, 1'b0, '{1'b0, 32'h0000_0000, 5'd0}},
		'{MODE_PUSH_BACK,  32'hA5A5_5A5A, 1'b0, '{1'b0, 32'h0000_0000, 5'd0}},
		'{MODE_POP_BACK,   32'h0000_0000, 1'b0, '{1'b0, 32'h0000_0000, 5'd0}},
		'{MODE_POP_FRONT,  32'h0000_0000, 1'b0, '{1'b0, 32'h0000_0000, 5'd0}},
		'{MODE_POP_FRONT,  32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0000, 5'd1}},
		'{MODE_POP_BACK,   32'h0000_0000, 1'b1, '{1'b1, 32'h7FFF_FFFF, 5'd0}},
		// drained again: a pop fails
		'{MODE_POP_BACK,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 5'd0}}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               mode;
	logic signed [WORD_W-1:0] data_in;
	logic                     out_valid;
	logic                     out_stall;
	logic                     ok;
	logic signed [WORD_W-1:0] data_out;
	logic [CNT_W-1:0]         count;

	// word on offer, kept in step with mode/data_in for the monitor
	deque_word_t              offered;

	// shadow deque
	logic [WORD_W-1:0]        shadow_ring [DEPTH];
	int unsigned              shadow_head;
	int unsigned              shadow_fill;

	deque_result_t            pending_results [$];
	int                       mismatches;
	int                       quiet_cycles;
	int                       idle_pct;
	int                       stall_pct;
	bit                       hold_request;

	double_ended_queue_core #(
		.DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.data_in  (data_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok       (ok),
		.data_out (data_out),
		.count    (count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Apply one operation to the shadow deque and return the result it gives.
	function automatic deque_result_t apply_deque_op(dq_mode_t op, logic [WORD_W-1:0] word);
		deque_result_t r;
		int unsigned   slot;
		r = '0;
		case (op)
			MODE_PUSH_FRONT: begin
				if (shadow_fill < DEPTH) begin
					shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
					shadow_ring[IDX_W'(shadow_head)] = word;
					shadow_fill++;
					r.ok = 1'b1;
				end
			end
			MODE_PUSH_BACK: begin
				if (shadow_fill < DEPTH) begin
					slot = (shadow_head + shadow_fill) % DEPTH;
					shadow_ring[IDX_W'(slot)] = word;
					shadow_fill++;
					r.ok = 1'b1;
				end
			end
			MODE_POP_FRONT: begin
				if (shadow_fill > 0) begin
					r.data = shadow_ring[IDX_W'(shadow_head)];
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_fill--;
					r.ok = 1'b1;
				end
			end
			default: begin
				if (shadow_fill > 0) begin
					slot = (shadow_head + shadow_fill - 1) % DEPTH;
					r.data = shadow_ring[IDX_W'(slot)];
					shadow_fill--;
					r.ok = 1'b1;
				end
			end
		endcase
		r.count = CNT_W'(shadow_fill);
		return r;
	endfunction

	// Monitor: check the outgoing word first, then predict the incoming one.
	// Both sides are sampled at the edge before the block's own updates land.
	always @(posedge clk) begin
		deque_result_t got;
		deque_result_t want;
		deque_result_t predicted;
		bit            moved;
		if (arst_n) begin
			moved = 1'b0;
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				got = '{ok, data_out, count};
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with none expected: ok=%0b data=%h count=%0d",
							got.ok, got.data, got.count);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: ok %0b/%0b data %h/%h count %0d/%0d (exp/act)",
								want.ok, got.ok, want.data, got.data, want.count, got.count);
					end
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				predicted = apply_deque_op(dq_mode_t'(mode), data_in);
				pending_results.push_back(offered.lit ? offered.want : predicted);
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
		end
	end

	// Receiver: random stalls, or a long hold-off when asked for one.
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Watchdog: end the run once nothing has moved for too long.
	initial begin
		wait (arst_n === 1'b1);
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("double_ended_queue_core verification failed");
		$finish;
	end

	// Offer one word after a random gap and hold it until it is taken.
	task automatic drive_word(input deque_word_t w);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= w.op;
		data_in  <= w.word;
		offered  <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Random bursts: fill runs push toward the full queue, drain runs pop toward
	// the empty one, mixed runs wander in between.
	task automatic run_random(input int n_words);
		deque_word_t w;
		int          sent;
		int          burst;
		int          flavor;
		sent = 0;
		while (sent < n_words) begin
			flavor = $urandom_range(2);
			burst  = $urandom_range(4, 22);
			repeat (burst) begin
				w = '0;
				case (flavor)
					0:       w.op = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
					1:       w.op = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
					default: w.op = dq_mode_t'($urandom_range(3));
				endcase
				case ($urandom_range(7))
					0:       w.word = 32'h8000_0000;
					1:       w.word = 32'h7FFF_FFFF;
					2:       w.word = 32'h0000_0000;
					3:       w.word = 32'hFFFF_FFFF;
					default: w.word = $urandom;
				endcase
				drive_word(w);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = MODE_PUSH_FRONT;
		data_in      = '0;
		offered      = '0;
		shadow_head  = 0;
		shadow_fill  = 0;
		mismatches   = 0;
		quiet_cycles = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_request = 1'b0;
		shadow_ring  = '{default: '0};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			drive_word(DIRECTED_ROWS[i]);

		// full rate, with one long receiver hold so the block backs up
		hold_request = 1'b1;
		run_random(PHASE_ITEMS);

		idle_pct  = 79;
		stall_pct = 0;
		run_random(PHASE_ITEMS);

		idle_pct  = 0;
		stall_pct = 79;
		run_random(PHASE_ITEMS);

		idle_pct  = 27;
		stall_pct = 27;
		run_random(PHASE_ITEMS);

		in_valid <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("double_ended_queue_core verification clean");
		else
			$display("double_ended_queue_core verification failed");
		$finish;
	end

endmodule

[double_ended_queue_core.f]
hdl/dq_pkg.sv
hdl/dq_cell.sv
hdl/double_ended_queue_core.sv
dv/double_ended_queue_core_test.sv
